[hdl/vfao_pkg.sv]
// Package for the voxel face ambient occlusion block: widths, neighbor tables,
// the queue entry type and the corner occlusion function.
// Depends on nothing; every other file imports it.
`timescale 1ns / 1ps

package vfao_pkg;

  localparam int NumNb      = 27;
  localparam int NumFaces   = 6;
  localparam int NumCorners = 4;
  localparam int ShadeW     = 4;
  localparam int ShadeLowW  = 64;
  localparam int ShadeHighW = 44;
  localparam int ShadeW_All = ShadeLowW + ShadeHighW;
  localparam int AoW        = 6;
  localparam int FaceW      = 3;
  localparam int NbW        = 5;
  localparam int SumW       = 7;

  localparam logic [AoW-1:0]   AoMax     = AoW'(32);
  localparam logic [FaceW-1:0] LastFace  = FaceW'(NumFaces - 1);
  localparam logic [FaceW-1:0] FirstFace = '0;

  // Default queue depth between the classifier and the face engine.
  localparam int QueueDepth = 2;

  // Axis neighbor that decides whether each face is exposed.
  localparam logic [NbW-1:0] FACE_NB [NumFaces] = '{5'd4, 5'd22, 5'd16, 5'd10, 5'd12, 5'd14};

  // Corner, first side and second side neighbor per face and corner.
  localparam logic [NbW-1:0] EDGE_TAB [NumFaces][NumCorners][3] = '{
    '{'{5'd0, 5'd1, 5'd3},    '{5'd2, 5'd1, 5'd5},
      '{5'd6, 5'd3, 5'd7},    '{5'd8, 5'd5, 5'd7}},
    '{'{5'd18, 5'd19, 5'd21}, '{5'd20, 5'd19, 5'd23},
      '{5'd24, 5'd21, 5'd25}, '{5'd26, 5'd23, 5'd25}},
    '{'{5'd6, 5'd7, 5'd15},   '{5'd8, 5'd7, 5'd17},
      '{5'd24, 5'd15, 5'd25}, '{5'd26, 5'd17, 5'd25}},
    '{'{5'd0, 5'd1, 5'd9},    '{5'd2, 5'd1, 5'd11},
      '{5'd18, 5'd9, 5'd19},  '{5'd20, 5'd11, 5'd19}},
    '{'{5'd0, 5'd3, 5'd9},    '{5'd6, 5'd3, 5'd15},
      '{5'd18, 5'd9, 5'd21},  '{5'd24, 5'd15, 5'd21}},
    '{'{5'd2, 5'd5, 5'd11},   '{5'd8, 5'd5, 5'd17},
      '{5'd20, 5'd11, 5'd23}, '{5'd26, 5'd17, 5'd23}}
  };

  // Four shade neighbors per face and corner.
  localparam logic [NbW-1:0] SHADE_TAB [NumFaces][NumCorners][4] = '{
    '{'{5'd0, 5'd1, 5'd3, 5'd4},     '{5'd1, 5'd2, 5'd4, 5'd5},
      '{5'd3, 5'd4, 5'd6, 5'd7},     '{5'd4, 5'd5, 5'd7, 5'd8}},
    '{'{5'd18, 5'd19, 5'd21, 5'd22}, '{5'd19, 5'd20, 5'd22, 5'd23},
      '{5'd21, 5'd22, 5'd24, 5'd25}, '{5'd22, 5'd23, 5'd25, 5'd26}},
    '{'{5'd6, 5'd7, 5'd15, 5'd16},   '{5'd7, 5'd8, 5'd16, 5'd17},
      '{5'd15, 5'd16, 5'd24, 5'd25}, '{5'd16, 5'd17, 5'd25, 5'd26}},
    '{'{5'd0, 5'd1, 5'd9, 5'd10},    '{5'd1, 5'd2, 5'd10, 5'd11},
      '{5'd9, 5'd10, 5'd18, 5'd19},  '{5'd10, 5'd11, 5'd19, 5'd20}},
    '{'{5'd0, 5'd3, 5'd9, 5'd12},    '{5'd3, 5'd6, 5'd12, 5'd15},
      '{5'd9, 5'd12, 5'd18, 5'd21},  '{5'd12, 5'd15, 5'd21, 5'd24}},
    '{'{5'd2, 5'd5, 5'd11, 5'd14},   '{5'd5, 5'd8, 5'd14, 5'd17},
      '{5'd11, 5'd14, 5'd20, 5'd23}, '{5'd14, 5'd17, 5'd23, 5'd26}}
  };

  // One classified voxel waiting for the face engine.
  typedef struct packed {
    logic [NumNb-1:0]      opaque;
    logic [ShadeW_All-1:0] shade;
    logic                  plant;
    logic [NumFaces-1:0]   exposed;
  } vfao_item_t;

  // Occlusion of one corner in 32nds, saturated.
  function automatic logic [AoW-1:0] corner_ao(
    input logic [NumNb-1:0]      opq,
    input logic [ShadeW_All-1:0] shade,
    input logic [FaceW-1:0]      face,
    input logic [1:0]            corner
  );
    logic            cb;
    logic            s1;
    logic            s2;
    logic [1:0]      level;
    logic [SumW-1:0] total;
    cb = opq[EDGE_TAB[face][corner][0]];
    s1 = opq[EDGE_TAB[face][corner][1]];
    s2 = opq[EDGE_TAB[face][corner][2]];
    level = (s1 && s2) ? 2'd3 : (2'(cb) + 2'(s1) + 2'(s2));
    total = {2'b00, level, 3'b000};
    for (int k = 0; k < 4; k++) begin
      total = total + SumW'(shade[ShadeW*SHADE_TAB[face][corner][k] +: ShadeW]);
    end
    corner_ao = (total > SumW'(AoMax)) ? AoMax : total[AoW-1:0];
  endfunction

endpackage

[hdl/vfao_if.sv]
// Handshake channels of the voxel face ambient occlusion block: voxel input
// and face result output. Depends on vfao_pkg.
`timescale 1ns / 1ps

interface vfao_in_if import vfao_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [NumNb-1:0]      opaque_neighbors;
  logic [ShadeLowW-1:0]  shade_low;
  logic [ShadeHighW-1:0] shade_high;
  logic                  plant_block;
  logic                  empty_block;

  modport source (output valid, opaque_neighbors, shade_low, shade_high, plant_block,
                  empty_block, input ready);
  modport sink (input valid, opaque_neighbors, shade_low, shade_high, plant_block,
                empty_block, output ready);
endinterface

interface vfao_out_if import vfao_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [FaceW-1:0] face_index;
  logic             plant_result;
  logic [AoW-1:0]   ao_corner0;
  logic [AoW-1:0]   ao_corner1;
  logic [AoW-1:0]   ao_corner2;
  logic [AoW-1:0]   ao_corner3;
  logic             last_face;

  modport source (output valid, face_index, plant_result, ao_corner0, ao_corner1,
                  ao_corner2, ao_corner3, last_face, input ready);
  modport sink (input valid, face_index, plant_result, ao_corner0, ao_corner1,
                ao_corner2, ao_corner3, last_face, output ready);
endinterface

[hdl/vfao_front.sv]
// Front end: takes voxel beats, finds the exposed faces and drops voxels that
// give no result. Depends on vfao_pkg and vfao_if.
`timescale 1ns / 1ps

module vfao_front import vfao_pkg::*; (
  vfao_in_if.sink    in_i,
  output vfao_item_t push_item_o,
  output logic       push_valid_o,
  input  logic       push_ready_i
);

  logic [NumFaces-1:0] exposed;

  // A face is exposed when its axis neighbor is not opaque.
  always_comb begin
    for (int f = 0; f < NumFaces; f++) begin
      exposed[f] = ~in_i.opaque_neighbors[FACE_NB[f]];
    end
  end

  // Accept whenever the queue has room; only voxels with work are pushed.
  assign in_i.ready   = push_ready_i;
  assign push_valid_o = in_i.valid && !in_i.empty_block && (exposed != '0);

  assign push_item_o.opaque  = in_i.opaque_neighbors;
  assign push_item_o.shade   = {in_i.shade_high, in_i.shade_low};
  assign push_item_o.plant   = in_i.plant_block;
  assign push_item_o.exposed = exposed;

endmodule

[hdl/vfao_fifo.sv]
// Short register queue of classified voxels between front and back end.
// Depends on vfao_pkg.
`timescale 1ns / 1ps

module vfao_fifo import vfao_pkg::*; #(
  parameter int Depth = QueueDepth
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  vfao_item_t push_item_i,
  input  logic       push_valid_i,
  output logic       push_ready_o,
  output vfao_item_t pop_item_o,
  output logic       pop_valid_o,
  input  logic       pop_i
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  vfao_item_t      mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            push;
  logic            pop;

  assign push_ready_o = (count_q != CntW'(Depth));
  assign pop_valid_o  = (count_q != '0);
  assign pop_item_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_i && pop_valid_o;

  // Pointer and fill count updates.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    unique case ({push, pop})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage, no reset needed.
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Depth))
    else $error("queue fill count out of range");
  a_ptr_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((count_q == '0) || (count_q == CntW'(Depth))) |-> (wr_ptr_q == rd_ptr_q))
    else $error("queue pointers disagree with fill count");
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0) |=> (count_q <= CntW'(1)))
    else $error("queue count jumped from empty");

endmodule

[hdl/vfao_back.sv]
// Back end: walks a voxel's exposed faces, one face per cycle unless the
// output stalls; drives the result register. Depends on vfao_pkg, vfao_if.
`timescale 1ns / 1ps

module vfao_back import vfao_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  vfao_item_t  item_i,
  input  logic        item_valid_i,
  output logic        item_pop_o,
  vfao_out_if.source  out_o
);

  // Voxel under work.
  logic                  busy_q, busy_d;
  logic [NumNb-1:0]      opq_q;
  logic [ShadeW_All-1:0] shade_q;
  logic                  plant_q;
  logic [NumFaces-1:0]   mask_q, mask_d;
  logic [FaceW-1:0]      face_q, face_d;
  logic [AoW-1:0]        min_q, min_d;

  // Result register.
  logic                  out_valid_q;
  logic [FaceW-1:0]      face_index_q;
  logic                  plant_result_q;
  logic [AoW-1:0]        ao_q [NumCorners];
  logic                  last_q;

  logic [FaceW-1:0]      low_face;
  logic [FaceW-1:0]      cur_face;
  logic [AoW-1:0]        corner [NumCorners];
  logic [AoW-1:0]        step_min;
  logic [NumFaces-1:0]   mask_rest;
  logic                  emit;
  logic                  out_free;
  logic                  advance;
  logic                  done;
  logic                  load;

  // Lowest remaining exposed face.
  always_comb begin
    low_face = FirstFace;
    for (int f = NumFaces - 1; f >= 0; f--) begin
      if (mask_q[f]) begin
        low_face = FaceW'(f);
      end
    end
  end

  // Four corners of the current face, and the running plant minimum.
  always_comb begin
    cur_face = plant_q ? face_q : low_face;
    step_min = min_q;
    for (int c = 0; c < NumCorners; c++) begin
      corner[c] = corner_ao(opq_q, shade_q, cur_face, 2'(c));
      if (corner[c] < step_min) begin
        step_min = corner[c];
      end
    end
  end

  // Sequencing: a plant sweeps all six faces and emits once at the end.
  always_comb begin
    mask_rest  = mask_q & ~(NumFaces'(1) << cur_face);
    emit       = busy_q && (!plant_q || (face_q == LastFace));
    out_free   = !out_valid_q || out_o.ready;
    advance    = busy_q && (!emit || out_free);
    done       = advance && (plant_q ? (face_q == LastFace) : (mask_rest == '0));
    load       = (!busy_q || done) && item_valid_i;
    item_pop_o = load;

    busy_d = busy_q;
    mask_d = mask_q;
    face_d = face_q;
    min_d  = min_q;
    if (load) begin
      busy_d = 1'b1;
      mask_d = item_i.exposed;
      face_d = FirstFace;
      min_d  = AoMax;
    end else if (advance) begin
      busy_d = !done;
      mask_d = mask_rest;
      face_d = face_q + 1'b1;
      min_d  = step_min;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      if (emit && advance) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Work and result payload registers.
  always_ff @(posedge clk_i) begin
    mask_q <= mask_d;
    face_q <= face_d;
    min_q  <= min_d;
    if (load) begin
      opq_q   <= item_i.opaque;
      shade_q <= item_i.shade;
      plant_q <= item_i.plant;
    end
    if (emit && advance) begin
      face_index_q   <= plant_q ? FirstFace : cur_face;
      plant_result_q <= plant_q;
      last_q         <= done;
      for (int c = 0; c < NumCorners; c++) begin
        ao_q[c] <= plant_q ? step_min : corner[c];
      end
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.face_index   = face_index_q;
  assign out_o.plant_result = plant_result_q;
  assign out_o.ao_corner0   = ao_q[0];
  assign out_o.ao_corner1   = ao_q[1];
  assign out_o.ao_corner2   = ao_q[2];
  assign out_o.ao_corner3   = ao_q[3];
  assign out_o.last_face    = last_q;

  a_walk_has_faces: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && !plant_q) |-> (mask_q != '0))
    else $error("face walk running with no faces left");
  a_plant_face_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && plant_q) |-> (face_q <= LastFace))
    else $error("plant sweep ran past the last face");
  a_plant_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && plant_result_q) |-> (last_q && (face_index_q == FirstFace)))
    else $error("plant beat not marked as the final one");
  a_face_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (face_index_q <= LastFace))
    else $error("face index out of range");
  a_no_load_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && !done) |-> !load)
    else $error("new voxel loaded over one still in work");

endmodule

[hdl/voxel_face_ambient_occlusion_top.sv]
// Channel     Dir  Payload
// in_i        in   opaque_neighbors, shade_low, shade_high, plant_block, empty_block
// out_o       out  face_index, plant_result, ao_corner0..3, last_face
//
// The face engine works through a voxel's exposed faces in turn and may stall while a
// result waits; a plant always sweeps every face for the minimum.
// Empty voxels and voxels with no exposed face need only queue room and leave no beat.
// The front end and the face engine are parted by a short queue, and the result sits in
// an output register, so input beats flow while a result waits until the queue fills.
// Reset clears the queue and all valid flags; there is no clearing pass.
//
// Top level of the voxel face ambient occlusion block. Depends on vfao_pkg, vfao_if,
// vfao_front, vfao_fifo and vfao_back.
`timescale 1ns / 1ps

module voxel_face_ambient_occlusion_top import vfao_pkg::*; #(
  parameter int QDepth = QueueDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  vfao_in_if.sink     in_i,
  vfao_out_if.source  out_o
);

  vfao_item_t push_item;
  logic       push_valid;
  logic       push_ready;
  vfao_item_t pop_item;
  logic       pop_valid;
  logic       pop;

  // Classification of incoming voxels.
  vfao_front u_front (
    .in_i         (in_i),
    .push_item_o  (push_item),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready)
  );

  // Queue between the two halves.
  vfao_fifo #(
    .Depth (QDepth)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_item_i  (push_item),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .pop_item_o   (pop_item),
    .pop_valid_o  (pop_valid),
    .pop_i        (pop)
  );

  // Face engine and result register.
  vfao_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_i       (pop_item),
    .item_valid_i (pop_valid),
    .item_pop_o   (pop),
    .out_o        (out_o)
  );

endmodule
